// ----- rtl/x86pw_pkg.sv -----
// Package: types, constants and encodings for the x86 page walk block.
package x86pw_pkg;

  localparam int DIR_ENTRIES_DEF = 2048;
  localparam int SEGMENTS_DEF    = 16;

  localparam int AW = 52;
  localparam logic [AW-1:0] MASK52 = {AW{1'b1}};

  typedef enum logic [1:0] {
    ACT_DIR_WR  = 2'd0,
    ACT_SEG_WR  = 2'd1,
    ACT_XLATE   = 2'd2,
    ACT_ENT_RSP = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIR_INV   = 3'd1,
    ST_ENT_NODMP = 3'd2,
    ST_ENT_INV   = 3'd3,
    ST_ADDR_NODMP = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_PAE    = 2'd0,
    CFG_PAGING = 2'd1,
    CFG_SEGCNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIR_RD,
    S_SEARCH,
    S_OUT
  } fsm_t;

  // request from controller to segment search unit
  typedef struct packed {
    logic          start;
    logic [AW-1:0] pa;
  } srch_req_t;

  typedef struct packed {
    logic          done;
    logic          hit;
    logic [AW-1:0] off;
  } srch_rsp_t;

endpackage

// ----- rtl/x86pw_seg_search.sv -----
// Segment table memory and sequential physical-to-file search.
module x86pw_seg_search import x86pw_pkg::*; #(
  parameter int SEGMENTS = SEGMENTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [10:0]      wr_slot,
  input  logic [AW-1:0]    wr_base,
  input  logic [AW-1:0]    wr_len,
  input  logic [AW-1:0]    wr_file,
  input  logic [4:0]       seg_count,
  input  srch_req_t        req,
  output srch_rsp_t        rsp
);
  localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CW = $clog2(SEGMENTS + 1) + 1;

  logic [AW-1:0] base_mem [SEGMENTS];
  logic [AW-1:0] len_mem  [SEGMENTS];
  logic [AW-1:0] file_mem [SEGMENTS];

  logic [AW-1:0] base_q, len_q, file_q;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] lim;
  logic          busy_r, busy_nxt;
  logic          chk_r, chk_nxt;
  logic [AW-1:0] pa_r;
  logic          done_r, done_nxt, hit_r, hit_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [AW:0]   end_a;
  logic          in_rng;

  always_comb begin
    if ({1'b0, seg_count} > CW'(SEGMENTS)) lim = CW'(SEGMENTS);
    else lim = CW'(seg_count);
  end

  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, wr_slot} < 12'(SEGMENTS))) begin
      base_mem[wr_slot[IW-1:0]] <= wr_base;
      len_mem[wr_slot[IW-1:0]]  <= wr_len;
      file_mem[wr_slot[IW-1:0]] <= wr_file;
    end
    base_q <= base_mem[idx_nxt[IW-1:0]];
    len_q  <= len_mem[idx_nxt[IW-1:0]];
    file_q <= file_mem[idx_nxt[IW-1:0]];
  end

  assign end_a  = {1'b0, base_q} + {1'b0, len_q};
  assign in_rng = (pa_r >= base_q) && ({1'b0, pa_r} < end_a);

  always_comb begin
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    chk_nxt  = 1'b0;
    done_nxt = 1'b0;
    hit_nxt  = hit_r;
    off_nxt  = off_r;
    if (req.start) begin
      idx_nxt  = '0;
      hit_nxt  = 1'b0;
      if (lim == '0) begin
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        chk_nxt  = 1'b1;
      end
    end else if (busy_r && chk_r) begin
      if (in_rng) begin
        hit_nxt  = 1'b1;
        off_nxt  = (pa_r - base_q) + file_q;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else if (idx_r + 1'b1 >= lim) begin
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
        chk_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      chk_r  <= chk_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    off_r <= off_nxt;
    if (req.start) pa_r <= req.pa;
  end

  assign rsp.done = done_r;
  assign rsp.hit  = hit_r;
  assign rsp.off  = off_r;
endmodule

// ----- rtl/x86pw_ctrl.sv -----
// Walk controller: directory memory, walk state and result register.
module x86pw_ctrl import x86pw_pkg::*; #(
  parameter int DIR_ENTRIES = DIR_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pae_mode,
  input  logic          paging_on,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_action,
  input  logic [10:0]   in_slot,
  input  logic [63:0]   in_entry_data,
  input  logic [31:0]   in_virt_addr,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_kind,
  output logic [AW-1:0] out_file_offset,
  output logic [22:0]   out_bytes_left,
  output logic [2:0]    out_status,
  output srch_req_t     sreq,
  input  srch_rsp_t     srsp
);
  localparam int DW = $clog2(DIR_ENTRIES);

  logic [63:0] dir_mem [DIR_ENTRIES];
  logic [63:0] pde_q;

  fsm_t st_r, st_nxt;
  logic          pend_r, pend_nxt;
  logic [11:0]   poff_r, poff_nxt;
  logic [31:0]   va_r, va_nxt;
  logic          pae_r, pae_nxt;
  logic          is_rsp_r, is_rsp_nxt;   // search is final lookup
  logic [22:0]   left_r, left_nxt;
  logic          kind_r, kind_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [22:0]   bl_r, bl_nxt;
  logic [2:0]    stat_r, stat_nxt;

  logic          acc;
  logic [10:0]   didx;
  logic [63:0]   pde, pte;
  logic          idx_ok;
  logic [21:0]   loff;
  logic [AW-1:0] frame;

  assign acc = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE);
  assign didx = pae_mode ? in_virt_addr[31:21] : {1'b0, in_virt_addr[31:22]};

  always_ff @(posedge clk) begin
    if (acc && in_action == ACT_DIR_WR && ({1'b0, in_slot} < 12'(DIR_ENTRIES)))
      dir_mem[in_slot[DW-1:0]] <= in_entry_data;
    pde_q <= dir_mem[didx[DW-1:0]];
  end

  assign idx_ok = ({1'b0, (pae_r ? va_r[31:21] : {1'b0, va_r[31:22]})}
                   < 12'(DIR_ENTRIES));
  assign pde  = pae_r ? pde_q : {32'd0, pde_q[31:0]};
  assign pte  = pae_mode ? in_entry_data : {32'd0, in_entry_data[31:0]};
  assign loff = pae_r ? {1'b0, va_r[20:0]} : va_r[21:0];

  always_comb begin
    st_nxt     = st_r;
    pend_nxt   = pend_r;
    poff_nxt   = poff_r;
    va_nxt     = va_r;
    pae_nxt    = pae_r;
    is_rsp_nxt = is_rsp_r;
    left_nxt   = left_r;
    kind_nxt   = kind_r;
    off_nxt    = off_r;
    bl_nxt     = bl_r;
    stat_nxt   = stat_r;
    sreq.start = 1'b0;
    sreq.pa    = '0;
    frame      = '0;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          case (in_action)
            ACT_XLATE: begin
              pend_nxt = 1'b0;
              va_nxt   = in_virt_addr;
              pae_nxt  = pae_mode;
              if (!paging_on) begin
                sreq.start = 1'b1;
                sreq.pa    = AW'(in_virt_addr);
                is_rsp_nxt = 1'b1;
                left_nxt   = 23'd4096 - 23'(in_virt_addr[11:0]);
                st_nxt     = S_SEARCH;
              end else begin
                st_nxt = S_DIR_RD;
              end
            end
            ACT_ENT_RSP: begin
              if (pend_r) begin
                pend_nxt = 1'b0;
                if (!pte[0]) begin
                  kind_nxt = 1'b1; off_nxt = '0; bl_nxt = '0;
                  stat_nxt = ST_ENT_INV;
                  st_nxt   = S_OUT;
                end else begin
                  frame = pae_mode ? {pte[51:12], 12'd0} : AW'({pte[31:12], 12'd0});
                  sreq.start = 1'b1;
                  sreq.pa    = frame + AW'(poff_r);
                  is_rsp_nxt = 1'b1;
                  left_nxt   = 23'd4096 - 23'(poff_r);
                  st_nxt     = S_SEARCH;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DIR_RD: begin
        if (!idx_ok || !pde[0]) begin
          kind_nxt = 1'b1; off_nxt = '0; bl_nxt = '0;
          stat_nxt = ST_DIR_INV;
          st_nxt   = S_OUT;
        end else if (pde[7]) begin
          frame = pae_r ? {pde[51:21], 21'd0} : AW'({pde[31:22], 22'd0});
          sreq.start = 1'b1;
          sreq.pa    = frame + AW'(loff);
          is_rsp_nxt = 1'b1;
          left_nxt   = pae_r ? (23'h200000 - 23'(loff)) : (23'h400000 - 23'(loff));
          st_nxt     = S_SEARCH;
        end else begin
          sreq.start = 1'b1;
          sreq.pa    = pae_r ? ({pde[51:12], 12'd0} + AW'({va_r[20:12], 3'd0}))
                             : (AW'({pde[31:12], 12'd0}) + AW'({va_r[21:12], 2'd0}));
          is_rsp_nxt = 1'b0;
          st_nxt     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (srsp.done) begin
          st_nxt = S_OUT;
          if (is_rsp_r) begin
            kind_nxt = 1'b1;
            off_nxt  = srsp.hit ? srsp.off : '0;
            bl_nxt   = srsp.hit ? left_r : '0;
            stat_nxt = srsp.hit ? ST_OK : ST_ADDR_NODMP;
          end else begin
            kind_nxt = srsp.hit ? 1'b0 : 1'b1;
            off_nxt  = srsp.hit ? srsp.off : '0;
            bl_nxt   = '0;
            stat_nxt = srsp.hit ? ST_OK : ST_ENT_NODMP;
            if (srsp.hit) begin
              pend_nxt = 1'b1;
              poff_nxt = va_r[11:0];
            end
          end
        end
      end
      S_OUT: begin
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      pend_r <= 1'b0;
      poff_r <= '0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
      poff_r <= poff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r     <= va_nxt;
    pae_r    <= pae_nxt;
    is_rsp_r <= is_rsp_nxt;
    left_r   <= left_nxt;
    kind_r   <= kind_nxt;
    off_r    <= off_nxt;
    bl_r     <= bl_nxt;
    stat_r   <= stat_nxt;
  end

  assign out_valid       = (st_r == S_OUT);
  assign out_kind        = kind_r;
  assign out_file_offset = off_r;
  assign out_bytes_left  = bl_r;
  assign out_status      = stat_r;
endmodule

// ----- rtl/x86_page_walk_to_dump_offset.sv -----
// Top level: x86 page walk translating virtual addresses to dump file offsets.
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_ready  | action slot entry_data seg_* virt_addr
//  out_    | out | out_valid/out_ready| kind file_offset bytes_left status
//  cfg_    | in  | cfg_we             | cfg_index cfg_data
// A translate reads the directory (skipped with paging off), then searches the
// segment table before the result register is valid. The sequential
// segment-table search (one entry per cycle) sets the rate.
// One item at a time; input is stalled until the result transfer completes.
// Reset is synchronous; directory and segment memories are not cleared.
module x86_page_walk_to_dump_offset import x86pw_pkg::*; #(
  parameter int DIR_ENTRIES = DIR_ENTRIES_DEF,
  parameter int SEGMENTS    = SEGMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [4:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_action,
  input  logic [10:0]   in_slot,
  input  logic [63:0]   in_entry_data,
  input  logic [51:0]   in_seg_base,
  input  logic [51:0]   in_seg_length,
  input  logic [51:0]   in_seg_file_start,
  input  logic [31:0]   in_virt_addr,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_kind,
  output logic [51:0]   out_file_offset,
  output logic [22:0]   out_bytes_left,
  output logic [2:0]    out_status
);
  logic       pae_r, paging_r;
  logic [4:0] segcnt_r;
  srch_req_t  sreq;
  srch_rsp_t  srsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pae_r    <= 1'b0;
      paging_r <= 1'b0;
      segcnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAE:    pae_r    <= cfg_data[0];
        CFG_PAGING: paging_r <= cfg_data[0];
        CFG_SEGCNT: segcnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  x86pw_seg_search #(.SEGMENTS(SEGMENTS)) u_srch (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_valid && in_ready && in_action == ACT_SEG_WR),
    .wr_slot(in_slot), .wr_base(in_seg_base), .wr_len(in_seg_length),
    .wr_file(in_seg_file_start), .seg_count(segcnt_r),
    .req(sreq), .rsp(srsp)
  );

  x86pw_ctrl #(.DIR_ENTRIES(DIR_ENTRIES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .pae_mode(pae_r), .paging_on(paging_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_slot(in_slot), .in_entry_data(in_entry_data), .in_virt_addr(in_virt_addr),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_file_offset(out_file_offset), .out_bytes_left(out_bytes_left),
    .out_status(out_status), .sreq(sreq), .srsp(srsp)
  );
endmodule
